// ----- design/icv_pkg.sv -----
// Shared types and constants for the IPv4 address and prefix text checker.
package icv_pkg;

  // ASCII codes and limits of the text rules
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] DigitSpan    = 8'd10;
  localparam logic [9:0] OctetMax     = 10'd255;
  localparam logic [6:0] PrefixMax    = 7'd32;
  localparam logic [1:0] OctetDigits  = 2'd3;
  localparam logic [1:0] PrefixDigits = 2'd2;
  localparam logic [1:0] DotsNeeded   = 2'd3;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // Byte class
  typedef enum logic [1:0] {
    ClsDigit,
    ClsDot,
    ClsOther
  } cls_e;

  // Classified byte carried from front to back
  typedef struct packed {
    logic       is_prefix;
    logic       rec_end;
    cls_e       cls;
    logic [3:0] digit;
  } item_t;

endpackage

// ----- design/icv_in_if.sv -----
// Input channel: one text byte with its part tag and end marker.
interface icv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       action;
  logic       record_end;

  modport source (output valid, output char_code, output action, output record_end,
                  input ready);
  modport sink (input valid, input char_code, input action, input record_end,
                output ready);
endinterface

// ----- design/icv_out_if.sv -----
// Output channel: one validity bit per record.
interface icv_out_if;
  logic valid;
  logic ready;
  logic record_valid;

  modport source (output valid, output record_valid, input ready);
  modport sink (input valid, input record_valid, output ready);
endinterface

// ----- design/ipv4_cidr_text_validator_unit.sv -----
// Top level of the IPv4 address and prefix length text checker.
//
// Usage: text arrives one byte per transfer on in_i (valid/ready). Each byte
// carries action (0 = address text, 1 = prefix text) and record_end, which
// marks the last byte of a record. Address and prefix bytes may interleave.
// For every byte with record_end set, one result leaves on out_o carrying
// record_valid: 1 when the address is four dotted octets of 1 to 3 digits,
// no leading zero and at most 255, and the prefix is 1 to 2 digits at most 32.
// Throughput: one byte per cycle while the queue has room; the per-byte check
// is a single update of the back end's registers.
// Path: a result passes through the queue entry, then the output register,
// before it is valid on out_o.
// Reset: all check state, the queue and the output valid flag clear; in_i is
// ready as soon as reset is released.
// Stall: while out_o is stalled, address and prefix bytes keep flowing; an
// end byte waits in the two-entry queue, and in_i drops ready when it fills.
module ipv4_cidr_text_validator_unit (
  input logic       clk_i,
  input logic       rst_ni,
  icv_in_if.sink    in_i,
  icv_out_if.source out_o
);
  import icv_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  icv_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  icv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  icv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .out_o        (out_o)
  );

endmodule

// ----- design/icv_front.sv -----
// Front end: accept text bytes and classify them as digit, dot or other.
module icv_front (
  icv_in_if.sink         in_i,
  output logic           push_valid_o,
  output icv_pkg::item_t push_item_o,
  input  logic           push_ready_i
);
  import icv_pkg::*;

  logic [7:0] offset;
  logic       is_digit;

  // Decode the byte against the digit range and the dot
  assign offset   = in_i.char_code - ChZero;
  assign is_digit = (in_i.char_code >= ChZero) && (offset < DigitSpan);

  always_comb begin
    push_item_o.is_prefix = in_i.action;
    push_item_o.rec_end   = in_i.record_end;
    push_item_o.digit     = offset[3:0];
    if (is_digit) begin
      push_item_o.cls = ClsDigit;
    end else if (in_i.char_code == ChDot) begin
      push_item_o.cls = ClsDot;
    end else begin
      push_item_o.cls = ClsOther;
    end
  end

  // Pass the handshake through to the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ----- design/icv_queue.sv -----
// Short queue of classified bytes between front and back.
module icv_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  icv_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output icv_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);
  import icv_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry on push
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Occupancy follows the transfers on each side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not shrink on pop");

endmodule

// ----- design/icv_back.sv -----
// Back end: update the address and prefix checks and register the verdict.
module icv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  icv_pkg::item_t item_i,
  output logic           item_ready_o,
  icv_out_if.source      out_o
);
  import icv_pkg::*;

  logic [1:0] dots_q, dots_d;
  logic [1:0] odc_q, odc_d;
  logic [9:0] oval_q, oval_d;
  logic       olz_q, olz_d;
  logic       abad_q, abad_d;
  logic [1:0] pdc_q, pdc_d;
  logic [6:0] pval_q, pval_d;
  logic       pbad_q, pbad_d;
  logic       out_valid_q, out_valid_d;
  logic       out_rv_q, out_rv_d;
  logic       out_free, take, verdict;

  // Hold end bytes while the output register is occupied and out_o is not ready
  assign out_free     = !out_valid_q || out_o.ready;
  assign item_ready_o = !item_i.rec_end || out_free;
  assign take         = item_valid_i && item_ready_o;

  // Per-byte state update
  always_comb begin
    logic [9:0] oval_new;
    logic [6:0] pval_new;
    oval_new = {oval_q[6:0], 3'b000} + {oval_q[8:0], 1'b0} + 10'(item_i.digit);
    pval_new = {pval_q[3:0], 3'b000} + {pval_q[5:0], 1'b0} + 7'(item_i.digit);
    dots_d = dots_q;
    odc_d  = odc_q;
    oval_d = oval_q;
    olz_d  = olz_q;
    abad_d = abad_q;
    pdc_d  = pdc_q;
    pval_d = pval_q;
    pbad_d = pbad_q;
    if (take) begin
      if (item_i.is_prefix) begin
        case (item_i.cls)
          ClsDigit: begin
            if (pdc_q >= PrefixDigits) begin
              pbad_d = 1'b1;
            end else begin
              pval_d = pval_new;
              pdc_d  = pdc_q + 1'b1;
            end
          end
          default: pbad_d = 1'b1;
        endcase
      end else begin
        case (item_i.cls)
          ClsDigit: begin
            if (odc_q >= OctetDigits) begin
              abad_d = 1'b1;
            end else begin
              if (odc_q == '0) begin
                olz_d = (item_i.digit == '0);
              end else if (olz_q) begin
                abad_d = 1'b1;
              end
              oval_d = oval_new;
              odc_d  = odc_q + 1'b1;
              if (oval_new > OctetMax) begin
                abad_d = 1'b1;
              end
            end
          end
          ClsDot: begin
            if (odc_q == '0) begin
              abad_d = 1'b1;
            end
            if (dots_q >= DotsNeeded) begin
              abad_d = 1'b1;
            end else begin
              dots_d = dots_q + 1'b1;
            end
            odc_d  = '0;
            oval_d = '0;
            olz_d  = 1'b0;
          end
          default: abad_d = 1'b1;
        endcase
      end
    end
  end

  // Judge the record from the updated state
  assign verdict = !abad_d && (dots_d == DotsNeeded) && (odc_d != '0) &&
                   !pbad_d && (pdc_d != '0) && (pval_d <= PrefixMax);

  // Load or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_rv_d    = out_rv_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (take && item_i.rec_end) begin
      out_valid_d = 1'b1;
      out_rv_d    = verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dots_q      <= '0;
      odc_q       <= '0;
      oval_q      <= '0;
      olz_q       <= 1'b0;
      abad_q      <= 1'b0;
      pdc_q       <= '0;
      pval_q      <= '0;
      pbad_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (take && item_i.rec_end) begin
      dots_q      <= '0;
      odc_q       <= '0;
      oval_q      <= '0;
      olz_q       <= 1'b0;
      abad_q      <= 1'b0;
      pdc_q       <= '0;
      pval_q      <= '0;
      pbad_q      <= 1'b0;
      out_valid_q <= out_valid_d;
    end else begin
      dots_q      <= dots_d;
      odc_q       <= odc_d;
      oval_q      <= oval_d;
      olz_q       <= olz_d;
      abad_q      <= abad_d;
      pdc_q       <= pdc_d;
      pval_q      <= pval_d;
      pbad_q      <= pbad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rv_q <= out_rv_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.record_valid = out_rv_q;

  // Record state clears after an end byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.rec_end) |=> (dots_q == '0 && odc_q == '0 && pdc_q == '0 &&
                                  !abad_q && !pbad_q && oval_q == '0 && pval_q == '0))
    else $error("record state not cleared after end byte");
  // A new result appears only after an end byte transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take && item_i.rec_end))
    else $error("result raised without end byte");
  // Counters stay within their limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (odc_q <= OctetDigits) && (pdc_q <= PrefixDigits) && (dots_q <= DotsNeeded))
    else $error("digit or dot counter out of range");

endmodule
